[rtl/dapt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapt_pkg
// Shared types and constants for the dual-axis PID tracker.
// ----------------------------------------------------------------------------
package dapt_pkg;

  localparam int GAIN_W     = 20;
  localparam int LIMIT_W    = 15;
  localparam int ERR_W      = 16;
  localparam int TIME_W     = 32;
  localparam int CMD_W      = 16;
  localparam int INTEG_W    = 48;
  localparam int DVD_W      = 54;
  localparam int DVS_W      = 34;
  localparam int CNT_W      = 6;
  localparam int REG_IDX_W  = 3;

  // Integral divide by 15625: dividend width, byte counter and reciprocal
  localparam int          QI_W     = 56;
  localparam int          QI_CNT_W = 3;
  localparam logic [22:0] QI_RECIP = 23'd4398047;

  // Raw Q4 error thresholds, minimum time step in microseconds, divide constant
  localparam logic signed [ERR_W-1:0] LOST_LIMIT = -16'sd15968;
  localparam logic signed [ERR_W-1:0] SMALL_ERR  = 16'sd32;
  localparam logic [TIME_W-1:0]       MIN_DT_US  = 32'd1000;
  localparam logic [13:0]             US_PER_MS_X = 14'd15625;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_KP_YAW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI_YAW   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KD_YAW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KP_VERT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KI_VERT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KD_VERT  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_YAW  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MAX_VERT = 3'd7;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_RUN,
    TOP_PUT
  } top_state_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL1,
    LN_MUL2,
    LN_MUL3,
    LN_MUL4,
    LN_DIV,
    LN_DONE
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic [LIMIT_W-1:0] limit;
  } lane_gains_t;

endpackage

[rtl/dapt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dapt_div import dapt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  logic [DVS_W:0]   rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;

  // One shift-and-subtract step
  always_comb begin
    rem_sh  = {rem[DVS_W-1:0], dvd[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W - 1);
    end else if (busy) begin
      if (cnt == '0) busy <= 1'b0;
      cnt <= cnt - 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= dividend;
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      if (!rem_sub[DVS_W]) begin
        rem      <= rem_sub;
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/dapt_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapt_lane
// One PID axis: holds its integral and previous error, forms P, I and D.
// ----------------------------------------------------------------------------
module dapt_lane import dapt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  lane_ctrl_t              ctrl,
  input  lane_gains_t             gains,
  input  logic signed [ERR_W-1:0] err,
  input  logic [TIME_W-1:0]       dt,
  output logic                    done,
  output logic signed [CMD_W-1:0] cmd
);

  lane_state_t state, state_next;

  logic signed [INTEG_W-1:0] integ;
  logic signed [ERR_W-1:0]   prev;
  logic signed [ERR_W-1:0]   e;
  logic [TIME_W-1:0]         dt_q;
  logic signed [48:0]        prod_edt;
  logic [35:0]               pmag;
  logic                      e_neg;
  logic signed [ERR_W:0]     diff;
  logic                      diff_neg;
  logic [15:0]               diff_mag;
  logic [INTEG_W-1:0]        s_mag;
  logic                      s_neg;
  logic [35:0]               kd_diff;
  logic [35:0]               ki_hi;
  logic [51:0]               ki_lo;
  logic [DVD_W-1:0]          num_d;
  logic [DVD_W-1:0]          q_i;
  logic                      busy_i, busy_d;
  logic [QI_W-1:0]           quo_i;
  logic [DVD_W-1:0]          quo_d;
  logic                      div_start;
  logic [QI_W-1:0]           qi_dvd;
  logic [13:0]               qi_rem;
  logic [QI_CNT_W-1:0]       qi_cnt;
  logic [21:0]               qi_t;
  logic [43:0]               qi_prod;
  logic [7:0]                qi_digit;
  logic [21:0]               qi_part;
  logic signed [49:0]        s_wide;
  logic signed [INTEG_W-1:0] s_sat;
  logic                      near_zero;
  logic signed [INTEG_W-1:0] p_term, i_term, d_term, sum;
  logic signed [INTEG_W-1:0] lim;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= LN_IDLE;
    else     state <= state_next;
  end

  // Sequencing of one step
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    done       = 1'b0;
    case (state)
      LN_IDLE: if (ctrl.start) state_next = LN_MUL1;
      LN_MUL1: state_next = LN_MUL2;
      LN_MUL2: state_next = LN_MUL3;
      LN_MUL3: state_next = LN_MUL4;
      LN_MUL4: begin
        div_start  = 1'b1;
        state_next = LN_DIV;
      end
      LN_DIV:  if (!busy_i && !busy_d) state_next = LN_DONE;
      LN_DONE: begin
        done       = 1'b1;
        state_next = LN_IDLE;
      end
      default: state_next = LN_IDLE;
    endcase
  end

  // Saturating integral update and small-error test
  always_comb begin
    s_wide = 50'(integ) + 50'(prod_edt);
    if (s_wide > 50'sh0_7FFF_FFFF_FFFF)      s_sat = 48'sh7FFF_FFFF_FFFF;
    else if (s_wide < -50'sh0_8000_0000_0000) s_sat = 48'sh8000_0000_0000;
    else                                      s_sat = s_wide[INTEG_W-1:0];
    near_zero = (e > -SMALL_ERR) && (e < SMALL_ERR);
  end

  // Loop state: integral and previous error
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      integ <= '0;
      prev  <= '0;
    end else if (state == LN_MUL1) begin
      prev <= e;
    end else if (state == LN_MUL2) begin
      integ <= near_zero ? '0 : s_sat;
    end
  end

  // Multiply stages
  always_ff @(posedge clk) begin
    case (state)
      LN_IDLE: if (ctrl.start) begin
        e    <= err;
        dt_q <= dt;
      end
      LN_MUL1: begin
        prod_edt <= 49'(e) * $signed({1'b0, dt_q});
        e_neg    <= e[ERR_W-1];
        pmag     <= gains.kp * 16'(e[ERR_W-1] ? -17'(e) : 17'(e));
        diff     <= 17'(e) - 17'(prev);
      end
      LN_MUL2: begin
        s_neg    <= s_sat[INTEG_W-1];
        s_mag    <= s_sat[INTEG_W-1] ? 48'(-s_sat) : 48'(s_sat);
        diff_neg <= diff[ERR_W];
        diff_mag <= 16'(diff[ERR_W] ? -diff : diff);
      end
      LN_MUL3: begin
        ki_hi   <= gains.ki * s_mag[47:32];
        ki_lo   <= gains.ki * s_mag[31:0];
        kd_diff <= gains.kd * diff_mag;
      end
      default: ;
    endcase
  end

  // Dividends for the integral and derivative terms
  always_comb begin
    q_i   = {ki_hi, 18'b0} + DVD_W'(ki_lo[51:14]);
    num_d = DVD_W'(kd_diff) * DVD_W'(US_PER_MS_X);
  end

  // Integral term over 15625: one dividend byte per cycle, each quotient
  // byte found by a reciprocal multiply that is exact for any remainder.
  always_comb begin
    qi_t     = {qi_rem, qi_dvd[QI_W-1 -: 8]};
    qi_prod  = 44'(qi_t) * 44'(QI_RECIP);
    qi_digit = qi_prod[43:36];
    qi_part  = qi_t - 22'(qi_digit) * 22'(US_PER_MS_X);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_i <= 1'b0;
      qi_cnt <= '0;
    end else if (div_start) begin
      busy_i <= 1'b1;
      qi_cnt <= QI_CNT_W'(QI_W / 8 - 1);
    end else if (busy_i) begin
      if (qi_cnt == '0) busy_i <= 1'b0;
      qi_cnt <= qi_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      qi_dvd <= QI_W'(q_i);
      qi_rem <= '0;
      quo_i  <= '0;
    end else if (busy_i) begin
      qi_dvd <= {qi_dvd[QI_W-9:0], 8'b0};
      qi_rem <= qi_part[13:0];
      quo_i  <= {quo_i[QI_W-9:0], qi_digit};
    end
  end

  dapt_div u_div_d (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_d),
    .divisor  ({dt_q, 2'b00}),
    .busy     (busy_d),
    .quotient (quo_d)
  );

  // Sum the signed terms and clamp
  always_comb begin
    p_term = $signed(48'(pmag[35:8]));
    i_term = $signed({4'b0, quo_i[43:0]});
    d_term = $signed({4'b0, quo_d[43:0]});
    if (e_neg)    p_term = -p_term;
    if (s_neg)    i_term = -i_term;
    if (diff_neg) d_term = -d_term;
    sum = p_term + i_term + d_term;
    lim = $signed(48'(gains.limit));
    if (sum > lim)       cmd = CMD_W'(lim);
    else if (sum < -lim) cmd = CMD_W'(-lim);
    else                 cmd = sum[CMD_W-1:0];
  end

endmodule

[rtl/dual_axis_pid_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_axis_pid_tracker
// Yaw and vertical PID loops turning pixel errors into clamped commands.
// ----------------------------------------------------------------------------
// Input channel: err_horizontal, err_vertical, time_us, vehicle_ready,
// taken when in_valid is high and in_stall low. An item with vehicle_ready
// low produces nothing. Every other item produces one result on the output
// channel (yaw_command, vertical_command, target_lost), taken when
// out_valid is high and out_stall low.
// Items that need no PID work (target lost, first step, gap under 1 ms)
// go from acceptance to the put state and, once the output is free, into
// the output register; the next item is taken back in the idle state. A
// full step runs four multiply stages, then the bit-serial divider for the
// derivative term, with the integral term divided by its constant a byte
// per cycle alongside. Both lanes run side by side. One item is in work
// at a time; in_stall is high until its result has been moved into the
// output register. Gains and limits are written by the user on cfg_we/
// cfg_index/cfg_data only while idle; the block does not enforce this.
// Reset restores default gains and clears both loops and out_valid.
// A stalled result holds its value until taken.
// ----------------------------------------------------------------------------
module dual_axis_pid_tracker import dapt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ERR_W-1:0] err_horizontal,
  input  logic signed [ERR_W-1:0] err_vertical,
  input  logic [TIME_W-1:0]       time_us,
  input  logic                    vehicle_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [CMD_W-1:0] yaw_command,
  output logic signed [CMD_W-1:0] vertical_command,
  output logic                    target_lost
);

  top_state_t state, state_next;

  lane_gains_t       yaw_gains, vert_gains;
  lane_ctrl_t        lane_ctrl;
  logic [TIME_W-1:0] prev_time;
  logic              primed;
  logic [TIME_W-1:0] dt;
  logic              accept;
  logic              lost;
  logic              yaw_done, vert_done;
  logic              yaw_seen, vert_seen;
  logic signed [CMD_W-1:0] yaw_cmd, vert_cmd;
  logic signed [CMD_W-1:0] res_yaw, res_vert;
  logic                    res_lost;
  logic              out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_gains  <= '{kp: 20'd1114, ki: 20'd105, kd: 20'd197, limit: 15'd4096};
      vert_gains <= '{kp: 20'd4588, ki: 20'd1638, kd: 20'd1245, limit: 15'd6144};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP_YAW:   yaw_gains.kp     <= cfg_data;
        REG_KI_YAW:   yaw_gains.ki     <= cfg_data;
        REG_KD_YAW:   yaw_gains.kd     <= cfg_data;
        REG_KP_VERT:  vert_gains.kp    <= cfg_data;
        REG_KI_VERT:  vert_gains.ki    <= cfg_data;
        REG_KD_VERT:  vert_gains.kd    <= cfg_data;
        REG_MAX_YAW:  yaw_gains.limit  <= cfg_data[LIMIT_W-1:0];
        REG_MAX_VERT: vert_gains.limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && !in_stall;
  assign lost     = err_horizontal <= LOST_LIMIT;
  assign dt       = time_us - prev_time;
  assign out_free = !out_valid || !out_stall;

  // Next state and handshake
  always_comb begin
    state_next      = state;
    in_stall        = 1'b1;
    lane_ctrl.start = 1'b0;
    lane_ctrl.clear = 1'b0;
    case (state)
      TOP_IDLE: begin
        in_stall = 1'b0;
        if (accept && vehicle_ready) begin
          if (lost) begin
            lane_ctrl.clear = 1'b1;
            state_next      = TOP_PUT;
          end else if (primed && dt >= MIN_DT_US) begin
            lane_ctrl.start = 1'b1;
            state_next      = TOP_RUN;
          end else begin
            state_next = TOP_PUT;
          end
        end
      end
      TOP_RUN: if ((yaw_done || yaw_seen) && (vert_done || vert_seen)) state_next = TOP_PUT;
      TOP_PUT: if (out_free) state_next = TOP_IDLE;
      default: state_next = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= TOP_IDLE;
    else     state <= state_next;
  end

  // Timing state and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      primed    <= 1'b0;
      yaw_seen  <= 1'b0;
      vert_seen <= 1'b0;
    end else if (state == TOP_IDLE && accept && vehicle_ready) begin
      yaw_seen  <= 1'b0;
      vert_seen <= 1'b0;
      if (lost) begin
        prev_time <= '0;
        primed    <= 1'b0;
      end else if (!primed) begin
        prev_time <= time_us;
        primed    <= 1'b1;
      end else if (dt >= MIN_DT_US) begin
        prev_time <= time_us;
      end
    end else if (state == TOP_RUN) begin
      if (yaw_done)  yaw_seen  <= 1'b1;
      if (vert_done) vert_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == TOP_IDLE && accept) begin
      res_yaw  <= '0;
      res_vert <= '0;
      res_lost <= lost;
    end else if (state == TOP_RUN) begin
      if (yaw_done)  res_yaw  <= yaw_cmd;
      if (vert_done) res_vert <= vert_cmd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == TOP_PUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == TOP_PUT && out_free) begin
      yaw_command      <= res_yaw;
      vertical_command <= res_vert;
      target_lost      <= res_lost;
    end
  end

  dapt_lane u_yaw (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lane_ctrl),
    .gains (yaw_gains),
    .err   (err_horizontal),
    .dt    (dt),
    .done  (yaw_done),
    .cmd   (yaw_cmd)
  );

  dapt_lane u_vert (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lane_ctrl),
    .gains (vert_gains),
    .err   (err_vertical),
    .dt    (dt),
    .done  (vert_done),
    .cmd   (vert_cmd)
  );

endmodule
